/* rtl/core/motor_speed_pid_step_assert.svh */
// ----------------------------------------------------------------------------
// motor speed pid step: assertion macros
// shared concurrent assertion forms, clocked on clk and muted while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_PID_STEP_ASSERT_SVH
`define MOTOR_SPEED_PID_STEP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MSPID_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// consequent must hold in the cycle after the antecedent
`define MSPID_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* rtl/core/mspid_pkg.sv */
// ----------------------------------------------------------------------------
// mspid_pkg
// types and fixed constants shared by the motor speed pid step block
// ----------------------------------------------------------------------------
package mspid_pkg;

  // field and datapath widths
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = 17;
  localparam int TOTAL_W   = 32;
  localparam int DERR_W    = 18;
  localparam int ACC_W     = 50;

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK = 3'd5;

  // loop mode codes
  localparam logic [1:0] MODE_P   = 2'd0;
  localparam logic [1:0] MODE_PI  = 2'd1;
  localparam logic [1:0] MODE_PID = 2'd2;

  // error terms produced for one tick
  typedef struct packed {
    logic signed [ERR_W-1:0]   err;
    logic signed [TOTAL_W-1:0] total;
    logic signed [DERR_W-1:0]  derr;
  } err_stage_t;

endpackage

/* rtl/core/motor_speed_pid_step.sv */
// ----------------------------------------------------------------------------
// motor_speed_pid_step
// incremental pid speed controller with deadband, one control tick per request
// ----------------------------------------------------------------------------
// One request carries the measured encoder period and the duty now applied;
// one duty command comes back for every request, in order. The block takes a
// new request in every clock cycle while in_stall is low, and each request
// reaches the result register through a six-register pipeline
// (error, error history, three multipliers, sum, rounding, duty clamp). A
// stage moves whenever the stage after it is free, so requests keep being
// taken while a result waits under out_stall until every stage is full.
// The error is target_period minus measured_period and is forced to zero
// when -DEADBAND <= error < DEADBAND. The error sum saturates at the 32-bit
// signed rails and keeps running in every loop mode; the derivative term uses
// the difference of the two previous errors. The weighted sum is divided by
// 2**GAIN_SHIFT rounding toward zero and added to the present duty; a result
// of zero or below gives fallback_duty, one above 65535 gives 65535. Loop
// mode 3 acts as pid. Write the registers only while no request is in flight.
// ----------------------------------------------------------------------------
module motor_speed_pid_step #(
  parameter int DEADBAND   = 5,
  parameter int GAIN_SHIFT = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_wr_en,
  input  logic [mspid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mspid_pkg::DATA_W-1:0]        cfg_wdata,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mspid_pkg::DATA_W-1:0]        in_measured_period,
  input  logic [mspid_pkg::DATA_W-1:0]        in_present_duty,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mspid_pkg::DATA_W-1:0]        out_duty_command
);

  `include "motor_speed_pid_step_assert.svh"

  localparam int DATA_W  = mspid_pkg::DATA_W;
  localparam int ERR_W   = mspid_pkg::ERR_W;
  localparam int TOTAL_W = mspid_pkg::TOTAL_W;
  localparam int DERR_W  = mspid_pkg::DERR_W;
  localparam int ACC_W   = mspid_pkg::ACC_W;
  localparam int PP_W    = ERR_W + DATA_W;    // proportional product
  localparam int PI_W    = TOTAL_W + DATA_W;  // integral product
  localparam int PD_W    = DERR_W + DATA_W;   // derivative product

  // deadband edges: errors in [-DEADBAND, DEADBAND) are ignored
  localparam logic signed [ERR_W-1:0] DB_HI = ERR_W'(DEADBAND);
  localparam logic signed [ERR_W-1:0] DB_LO = -DB_HI;

  // added to a negative sum before the arithmetic shift, so it truncates toward zero
  localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((64'd1 << GAIN_SHIFT) - 64'd1);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic        [DATA_W-1:0] cfg_target_r;
  logic signed [DATA_W-1:0] cfg_gain_p_r;
  logic signed [DATA_W-1:0] cfg_gain_i_r;
  logic signed [DATA_W-1:0] cfg_gain_d_r;
  logic        [1:0]        cfg_mode_r;
  logic        [DATA_W-1:0] cfg_fallback_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_target_r   <= '0;
      cfg_gain_p_r   <= '0;
      cfg_gain_i_r   <= '0;
      cfg_gain_d_r   <= '0;
      cfg_mode_r     <= mspid_pkg::MODE_PID;
      cfg_fallback_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mspid_pkg::REG_TARGET:   cfg_target_r   <= cfg_wdata;
        mspid_pkg::REG_GAIN_P:   cfg_gain_p_r   <= cfg_wdata;
        mspid_pkg::REG_GAIN_I:   cfg_gain_i_r   <= cfg_wdata;
        mspid_pkg::REG_GAIN_D:   cfg_gain_d_r   <= cfg_wdata;
        mspid_pkg::REG_MODE:     cfg_mode_r     <= cfg_wdata[1:0];
        mspid_pkg::REG_FALLBACK: cfg_fallback_r <= cfg_wdata;
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage can load when it is empty or moving on
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

  always_comb begin
    rdy_out = !out_valid_r || !out_stall;
    rdy5    = !v5_r || rdy_out;
    rdy4    = !v4_r || rdy5;
    rdy3    = !v3_r || rdy4;
    rdy2    = !v2_r || rdy3;
    rdy1    = !v1_r || rdy2;
  end

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy4)    v4_r        <= v3_r;
      if (rdy5)    v5_r        <= v4_r;
      if (rdy_out) out_valid_r <= v5_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: error against the setpoint, deadband
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [ERR_W-1:0]  err1_r;
  logic        [DATA_W-1:0] duty1_r;

  always_comb begin
    err_raw = signed'({1'b0, cfg_target_r}) - signed'({1'b0, in_measured_period});
    err_nxt = (err_raw >= DB_LO && err_raw < DB_HI) ? '0 : err_raw;
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      err1_r  <= err_nxt;
      duty1_r <= in_present_duty;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: error history (sum, lagged difference) updated in request order
  // --------------------------------------------------------------------------
  mspid_pkg::err_stage_t    stage2;
  logic        [DATA_W-1:0] duty2_r;

  mspid_err_state u_err_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (v1_r && rdy2),
    .err_i   (err1_r),
    .stage_o (stage2)
  );

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      duty2_r <= duty1_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: the three gain products, each registered
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0]   prod_p_nxt;
  logic signed [PI_W-1:0]   prod_i_nxt;
  logic signed [PD_W-1:0]   prod_d_nxt;
  logic signed [PP_W-1:0]   prod_p3_r;
  logic signed [PI_W-1:0]   prod_i3_r;
  logic signed [PD_W-1:0]   prod_d3_r;
  logic        [DATA_W-1:0] duty3_r;

  always_comb begin
    prod_p_nxt = stage2.err   * cfg_gain_p_r;
    prod_i_nxt = stage2.total * cfg_gain_i_r;
    prod_d_nxt = stage2.derr  * cfg_gain_d_r;
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      prod_p3_r <= prod_p_nxt;
      prod_i3_r <= prod_i_nxt;
      prod_d3_r <= prod_d_nxt;
      duty3_r   <= duty2_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: weighted sum, terms picked by the loop mode
  // --------------------------------------------------------------------------
  logic                     use_i;
  logic                     use_d;
  logic signed [ACC_W-1:0]  term_i;
  logic signed [ACC_W-1:0]  term_d;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  acc4_r;
  logic        [DATA_W-1:0] duty4_r;

  always_comb begin
    use_i = 1'b1;
    use_d = 1'b1;
    case (cfg_mode_r)
      mspid_pkg::MODE_P: begin
        use_i = 1'b0;
        use_d = 1'b0;
      end
      mspid_pkg::MODE_PI: begin
        use_d = 1'b0;
      end
      default: ;  // pid, and the spare code behaves the same
    endcase
    term_i  = use_i ? ACC_W'(prod_i3_r) : ACC_W'(0);
    term_d  = use_d ? ACC_W'(prod_d3_r) : ACC_W'(0);
    acc_nxt = ACC_W'(prod_p3_r) + term_i + term_d;
  end

  always_ff @(posedge clk) begin
    if (v3_r && rdy4) begin
      acc4_r  <= acc_nxt;
      duty4_r <= duty3_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: gain scaling, rounded toward zero
  // --------------------------------------------------------------------------
  logic signed [ACC_W-1:0]  acc_biased;
  logic signed [ACC_W-1:0]  corr_nxt;
  logic signed [ACC_W-1:0]  corr5_r;
  logic        [DATA_W-1:0] duty5_r;

  always_comb begin
    acc_biased = acc4_r[ACC_W-1] ? (acc4_r + RND_BIAS) : acc4_r;
    corr_nxt   = acc_biased >>> GAIN_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (v4_r && rdy5) begin
      corr5_r <= corr_nxt;
      duty5_r <= duty4_r;
    end
  end

  // --------------------------------------------------------------------------
  // result register: corrected duty, fallback below one, clipped at the top
  // --------------------------------------------------------------------------
  logic signed [ACC_W:0]    duty_sum;
  logic        [DATA_W-1:0] duty_nxt;
  logic        [DATA_W-1:0] duty_out_r;

  always_comb begin
    duty_sum = signed'((ACC_W+1)'({1'b0, duty5_r})) + (ACC_W+1)'(corr5_r);
    if (duty_sum <= 0) begin
      duty_nxt = cfg_fallback_r;
    end else if (duty_sum > signed'((ACC_W+1)'({DATA_W{1'b1}}))) begin
      duty_nxt = {DATA_W{1'b1}};
    end else begin
      duty_nxt = duty_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (v5_r && rdy_out) begin
      duty_out_r <= duty_nxt;
    end
  end

  assign out_duty_command = duty_out_r;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // upstream back-pressure only arises once a result is held at the output
  `MSPID_ASSERT_NOW(a_stall_only_when_out_full, in_stall, out_valid_r)
  // a request taken always occupies the first stage next cycle
  `MSPID_ASSERT_NEXT(a_request_enters_pipe, in_valid && !in_stall, v1_r)
  // no result appears without a request behind it
  `MSPID_ASSERT_NEXT(a_no_invented_result, out_valid_r && !out_stall && !v5_r, !out_valid_r)

endmodule

/* rtl/core/mspid_err_state.sv */
// ----------------------------------------------------------------------------
// mspid_err_state
// error history: saturating error sum, lagged error difference, one tick per load
// ----------------------------------------------------------------------------
module mspid_err_state (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  logic signed [mspid_pkg::ERR_W-1:0]      err_i,
  output mspid_pkg::err_stage_t                   stage_o
);

  `include "motor_speed_pid_step_assert.svh"

  localparam int ERR_W   = mspid_pkg::ERR_W;
  localparam int TOTAL_W = mspid_pkg::TOTAL_W;
  localparam int DERR_W  = mspid_pkg::DERR_W;

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

  logic signed [TOTAL_W-1:0] error_total_r;
  logic signed [ERR_W-1:0]   error_last_r;
  logic signed [ERR_W-1:0]   error_before_last_r;

  logic signed [TOTAL_W:0]   sum_wide;
  logic signed [TOTAL_W-1:0] total_nxt;
  logic signed [DERR_W-1:0]  derr_nxt;

  always_comb begin
    sum_wide = (TOTAL_W+1)'(error_total_r) + (TOTAL_W+1)'(err_i);
    // top two bits disagree: clip to the rail on the side of the sign
    if (sum_wide[TOTAL_W] != sum_wide[TOTAL_W-1]) begin
      total_nxt = sum_wide[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
    end else begin
      total_nxt = sum_wide[TOTAL_W-1:0];
    end
    derr_nxt = DERR_W'(error_last_r) - DERR_W'(error_before_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_total_r       <= '0;
      error_last_r        <= '0;
      error_before_last_r <= '0;
    end else if (load) begin
      error_total_r       <= total_nxt;
      error_last_r        <= err_i;
      error_before_last_r <= error_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_o.err   <= err_i;
      stage_o.total <= total_nxt;
      stage_o.derr  <= derr_nxt;
    end
  end

  `MSPID_ASSERT_NEXT(a_sum_holds_top, load && error_total_r == TOTAL_MAX && err_i >= 0, error_total_r == TOTAL_MAX)
  `MSPID_ASSERT_NEXT(a_sum_holds_bottom, load && error_total_r == TOTAL_MIN && err_i <= 0, error_total_r == TOTAL_MIN)

endmodule

/* dv/mspid_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mspid_tb_pkg
// duty prediction and in-order checking for the motor speed pid step bench
// ----------------------------------------------------------------------------
package mspid_tb_pkg;

  localparam int DATA_W    = mspid_pkg::DATA_W;
  localparam int CFG_IDX_W = mspid_pkg::CFG_IDX_W;
  localparam int ERR_W     = mspid_pkg::ERR_W;
  localparam int TOTAL_W   = mspid_pkg::TOTAL_W;
  localparam int DERR_W    = mspid_pkg::DERR_W;

  localparam int DEADBAND    = 5;
  localparam int GAIN_SHIFT  = 8;
  localparam int DUTY_MAX    = 65535;

  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // indices past the last register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // unused mode code, behaves as pid
  localparam logic [1:0] MODE_SPARE = 2'd3;

  class pid_tick_checker;
    // register copies
    logic [DATA_W-1:0]        target_period;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic [1:0]               loop_mode;
    logic [DATA_W-1:0]        fallback_duty;

    // error history
    logic signed [TOTAL_W-1:0] err_accum;
    logic signed [ERR_W-1:0]   err_prev;
    logic signed [ERR_W-1:0]   err_prev2;

    logic [DATA_W-1:0] duty_due[$];
    int                mismatches;

    function new();
      target_period = '0;
      gain_p        = '0;
      gain_i        = '0;
      gain_d        = '0;
      loop_mode     = mspid_pkg::MODE_PID;
      fallback_duty = '0;
      err_accum     = '0;
      err_prev      = '0;
      err_prev2     = '0;
      mismatches    = 0;
    endfunction

    function void note_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        mspid_pkg::REG_TARGET:   target_period = data;
        mspid_pkg::REG_GAIN_P:   gain_p = data;
        mspid_pkg::REG_GAIN_I:   gain_i = data;
        mspid_pkg::REG_GAIN_D:   gain_d = data;
        mspid_pkg::REG_MODE:     loop_mode = data[1:0];
        mspid_pkg::REG_FALLBACK: fallback_duty = data;
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] predict_duty(logic [DATA_W-1:0] measured,
                                             logic [DATA_W-1:0] present);
      logic signed [ERR_W-1:0]  err;
      logic signed [DERR_W-1:0] derr;
      longint                   sum;
      longint                   acc;
      longint                   corr;
      longint                   duty;

      err = $signed({1'b0, target_period}) - $signed({1'b0, measured});
      if (err >= -DEADBAND && err < DEADBAND) begin
        err = '0;
      end

      // saturating running sum, kept in every mode
      sum = longint'(err_accum) + longint'(err);
      if (sum > SUM_MAX) begin
        sum = SUM_MAX;
      end else if (sum < SUM_MIN) begin
        sum = SUM_MIN;
      end
      err_accum = sum[TOTAL_W-1:0];

      // derivative from the two earlier errors, before this one goes in
      derr      = err_prev - err_prev2;
      err_prev2 = err_prev;
      err_prev  = err;

      acc = longint'(err) * longint'(gain_p);
      if (loop_mode != mspid_pkg::MODE_P) begin
        acc += longint'(err_accum) * longint'(gain_i);
      end
      if (loop_mode >= mspid_pkg::MODE_PID) begin
        acc += longint'(derr) * longint'(gain_d);
      end

      // shift the magnitude so the quotient rounds toward zero
      corr = (acc < 0) ? -((-acc) >> GAIN_SHIFT) : (acc >> GAIN_SHIFT);

      duty = longint'(present) + corr;
      if (duty <= 0) begin
        duty = longint'(fallback_duty);
      end else if (duty > DUTY_MAX) begin
        duty = DUTY_MAX;
      end
      return duty[DATA_W-1:0];
    endfunction

    function void note_tick(logic [DATA_W-1:0] measured, logic [DATA_W-1:0] present);
      duty_due.push_back(predict_duty(measured, present));
    endfunction

    function void check_duty(logic [DATA_W-1:0] actual);
      logic [DATA_W-1:0] want;
      if (duty_due.size() == 0) begin
        mismatches++;
        $display("%0t: duty_command expected none, got %0d", $time, actual);
        return;
      end
      want = duty_due.pop_front();
      if (actual !== want) begin
        mismatches++;
        $display("%0t: duty_command expected %0d, got %0d", $time, want, actual);
      end
    endfunction

    function int outstanding();
      return duty_due.size();
    endfunction
  endclass

endpackage

/* dv/tb_motor_speed_pid_step.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_speed_pid_step
// self-checking bench: directed ticks and random loop settings, every duty
// command compared in order with a cycle-free prediction of the pid step
// ----------------------------------------------------------------------------
module tb_motor_speed_pid_step;

  localparam int DATA_W    = mspid_pkg::DATA_W;
  localparam int CFG_IDX_W = mspid_pkg::CFG_IDX_W;

  localparam int RESET_CYCLES   = 9;
  localparam int DRAIN_SLACK    = 12;   // pipeline is six deep, leave room
  localparam int HOLD_CYCLES    = 80;   // long receiver hold-off
  localparam int IDLE_PCT       = 12;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_REQUESTS = 250;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_measured_period = '0;
  logic [DATA_W-1:0]    in_present_duty = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_duty_command;

  // calm switches off idling on both sides
  bit calm = 1'b0;
  // hold-off requests from the stimulus, served by the receiver
  int holds_asked = 0;
  int holds_done = 0;

  mspid_tb_pkg::pid_tick_checker ticks;

  motor_speed_pid_step u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_measured_period (in_measured_period),
    .in_present_duty    (in_present_duty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_duty_command   (out_duty_command)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // both handshakes sampled at the edge, before any update lands
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        ticks.note_tick(in_measured_period, in_present_duty);
      end
      if (out_valid && !out_stall) begin
        ticks.check_duty(out_duty_command);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when asked so the pipe fills
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // one request, with random idle cycles in front; returns at the accepting edge
  task automatic send_tick(input logic [DATA_W-1:0] measured,
                           input logic [DATA_W-1:0] present);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid           <= 1'b1;
    in_measured_period <= measured;
    in_present_duty    <= present;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and let every outstanding duty command come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (ticks.outstanding() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // leaves the write enable high so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    ticks.note_reg(idx, data);
  endtask

  task automatic set_loop(input logic [DATA_W-1:0] target,
                          input logic [DATA_W-1:0] gp,
                          input logic [DATA_W-1:0] gi,
                          input logic [DATA_W-1:0] gd,
                          input logic [DATA_W-1:0] mode_word,
                          input logic [DATA_W-1:0] fallback);
    write_reg(mspid_pkg::REG_TARGET, target);
    write_reg(mspid_pkg::REG_GAIN_P, gp);
    write_reg(mspid_pkg::REG_GAIN_I, gi);
    write_reg(mspid_pkg::REG_GAIN_D, gd);
    write_reg(mspid_pkg::REG_MODE, mode_word);
    write_reg(mspid_pkg::REG_FALLBACK, fallback);
    cfg_wr_en <= 1'b0;
  endtask

  // half the time modest gains so the duty is not always pinned, else any value or the rails
  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return DATA_W'($urandom);
      1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return DATA_W'(int'($urandom_range(600)) - 300);
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] target;
    logic [DATA_W-1:0] present;
    int                period;

    ticks = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero gains pass the duty through, zero duty falls back
    send_tick(16'd0, 16'd0);
    send_tick(16'hFFFF, 16'd777);
    wait_idle();

    // proportional only, unit gain: deadband edges around the setpoint,
    // fallback on a negative duty and clamping at the top
    set_loop(16'd1000, 16'd256, 16'd0, 16'd0, DATA_W'(mspid_pkg::MODE_P), 16'd1234);
    send_tick(16'd1005, 16'd3000);
    send_tick(16'd1006, 16'd3000);
    send_tick(16'd996, 16'd3000);
    send_tick(16'd995, 16'd3000);
    send_tick(16'd0, 16'd0);
    send_tick(16'hFFFF, 16'd0);
    send_tick(16'd0, 16'hFFFF);
    wait_idle();

    // extreme gains and setpoint, integral path on
    set_loop(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, DATA_W'(mspid_pkg::MODE_PI),
             16'hFFFF);
    send_tick(16'd0, 16'd0);
    send_tick(16'hFFFF, 16'hFFFF);
    send_tick(16'hFFFF, 16'd0);
    send_tick(16'd0, 16'h8000);
    wait_idle();

    // full pid, derivative sees the lagged difference of earlier errors
    set_loop(16'd30000, 16'h8000, 16'h7FFF, 16'h8000, DATA_W'(mspid_pkg::MODE_PID),
             16'd1);
    send_tick(16'd0, 16'd40000);
    send_tick(16'd30000, 16'd40000);
    send_tick(16'd60000, 16'd40000);
    send_tick(16'd30000, 16'd40000);
    wait_idle();

    // writes past the last register are dropped; the spare mode code runs as pid
    write_reg(mspid_tb_pkg::REG_SPARE_6, 16'hFFFF);
    write_reg(mspid_tb_pkg::REG_SPARE_7, 16'h5A5A);
    set_loop(16'd500, 16'd3, 16'd1, 16'hFFF0, DATA_W'(mspid_tb_pkg::MODE_SPARE), 16'd99);
    send_tick(16'd480, 16'd20000);
    send_tick(16'd530, 16'd20000);
    send_tick(16'd500, 16'd20000);
    wait_idle();

    // small negative products must round toward zero, not down
    set_loop(16'd100, 16'd1, 16'd0, 16'd0, DATA_W'(mspid_pkg::MODE_P), 16'd7);
    send_tick(16'd106, 16'd500);
    send_tick(16'd94, 16'd500);
    send_tick(16'd355, 16'd500);
    send_tick(16'd356, 16'd500);
    wait_idle();

    // random settings per phase, every mode code in turn, history carried over
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = (ph == 3);
      if ($urandom_range(1)) begin
        write_reg($urandom_range(1) ? mspid_tb_pkg::REG_SPARE_6 : mspid_tb_pkg::REG_SPARE_7,
                  DATA_W'($urandom));
      end
      target = (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : DATA_W'($urandom);
      set_loop(target, pick_gain(), pick_gain(), pick_gain(),
               {(DATA_W-2)'($urandom), 2'(ph)},
               (ph == 2) ? 16'd0 : (ph == 5) ? 16'hFFFF : DATA_W'($urandom));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // long hold-off while requests keep coming, so the input backs up
        if (n == 60 && (ph == 1 || ph == 4)) begin
          holds_asked++;
        end
        // near the setpoint for the deadband, moderate swings, or anywhere
        case ($urandom_range(9))
          0, 1, 2, 3: period = int'(target) + int'($urandom_range(16)) - 8;
          4, 5, 6:    period = int'(target) + int'($urandom_range(4000)) - 2000;
          default:    period = int'($urandom_range(65535));
        endcase
        if (period < 0) begin
          period = 0;
        end else if (period > 65535) begin
          period = 65535;
        end
        present = ($urandom_range(2) == 0) ? DATA_W'($urandom_range(64))
                                           : DATA_W'($urandom);
        send_tick(DATA_W'(period), present);
      end
      wait_idle();
    end

    if (ticks.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
